FILE: hdl/npp_pkg.sv
// ----------------------------------------------------------------------------
// npp_pkg
// Shared types and constants for the nearest-point-on-polyline block.
// ----------------------------------------------------------------------------
package npp_pkg;

    localparam int DIST_W = 48;

    localparam logic [DIST_W-1:0] MAX_DIST_RESET = 48'd655360000;
    localparam logic [DIST_W-1:0] DIST_INFINITY  = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_CAND = 2'd1,
        STATUS_TOO_FAR = 2'd2
    } status_t;

endpackage

FILE: hdl/nearest_point_on_polyline.sv
// ----------------------------------------------------------------------------
// nearest_point_on_polyline
// Snaps the origin onto a stream of polyline vertices and reports the
// nearest segment projection at the end of each query.
// ----------------------------------------------------------------------------
// Vertices arrive on the in_* channel (valid/ready), one item per vertex,
// relative to the query point. A vertex that is not first_of_edge closes a
// segment from the previous vertex of the same query, if there is one; the
// origin is projected onto it using one shared signed multiplier and a
// restoring divider producing one quotient bit per cycle. The divider runs
// only when the projection falls inside the segment; else it clamps to an
// end. in_ready is high only while the sequencer is idle.
// On last_of_query one item appears on out_* (valid/ready) from an output
// register; the next vertex may be accepted while it waits. A second result
// that finds the output register still full holds the sequencer until the
// receiver takes the first one.
// cfg_we writes max_distance_sq at once; it should only be written while idle.
// Reset clears all query state and loads the default distance limit.
// ----------------------------------------------------------------------------
module nearest_point_on_polyline #(
    parameter int COORD_WIDTH     = 24,
    parameter int T_FRACTION_BITS = 16,
    parameter int EDGE_ID_WIDTH   = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [npp_pkg::DIST_W-1:0]      cfg_wdata,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [COORD_WIDTH-1:0]   east,
    input  logic signed [COORD_WIDTH-1:0]   north,
    input  logic [EDGE_ID_WIDTH-1:0]        edge_id,
    input  logic                            on_bridge,
    input  logic                            first_of_edge,
    input  logic                            last_of_query,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [EDGE_ID_WIDTH-1:0]        best_edge,
    output logic signed [COORD_WIDTH-1:0]   snapped_east,
    output logic signed [COORD_WIDTH-1:0]   snapped_north,
    output logic [npp_pkg::DIST_W-1:0]      snapped_dist_sq,
    output logic signed [COORD_WIDTH:0]     dir_east,
    output logic signed [COORD_WIDTH:0]     dir_north,
    output logic                            best_on_bridge
);

    localparam int C     = COORD_WIDTH;
    localparam int F     = T_FRACTION_BITS;
    localparam int DW    = npp_pkg::DIST_W;
    localparam int MW    = (C + 1 > F + 1) ? C + 1 : F + 1;
    localparam int PW    = 2 * MW;
    localparam int AW0   = (2 * C + 3 > PW) ? 2 * C + 3 : PW;
    localparam int ACC_W = (AW0 > DW) ? AW0 : DW;
    localparam int CNT_W = $clog2(F + 1);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (F - 1);
    localparam logic [CNT_W-1:0]        CNT_LAST   = CNT_W'(F - 1);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_P1   = 15'b000000000000010,
        S_P2   = 15'b000000000000100,
        S_P3   = 15'b000000000001000,
        S_P4   = 15'b000000000010000,
        S_P5   = 15'b000000000100000,
        S_CHK  = 15'b000000001000000,
        S_DIV  = 15'b000000010000000,
        S_T1   = 15'b000000100000000,
        S_T2   = 15'b000001000000000,
        S_T3   = 15'b000010000000000,
        S_D1   = 15'b000100000000000,
        S_D2   = 15'b001000000000000,
        S_D3   = 15'b010000000000000,
        S_FIN  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // query state
    logic [DW-1:0]            max_dist_reg;
    logic signed [C-1:0]      prev_e_reg, prev_n_reg;
    logic                     prev_valid_reg;
    logic [DW-1:0]            best_dist_reg;
    logic                     found_reg;
    logic [EDGE_ID_WIDTH-1:0] best_id_reg;
    logic signed [C-1:0]      best_e_reg, best_n_reg;
    logic signed [C:0]        best_de_reg, best_dn_reg;
    logic                     best_bridge_reg;

    // segment working registers
    logic signed [C-1:0]      a_e_reg, a_n_reg, b_e_reg, b_n_reg;
    logic signed [C:0]        sx_reg, sy_reg;
    logic [EDGE_ID_WIDTH-1:0] id_reg;
    logic                     bridge_reg, last_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [ACC_W-1:0]  len_reg, dot_reg, acc_reg;
    logic [ACC_W-1:0]         rem_reg;
    logic [F-1:0]             t_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [C-1:0]      px_reg, py_reg;

    // output register
    logic                     out_valid_reg;
    npp_pkg::status_t         status_reg;
    logic [EDGE_ID_WIDTH-1:0] out_id_reg;
    logic signed [C-1:0]      out_e_reg, out_n_reg;
    logic [DW-1:0]            out_dist_reg;
    logic signed [C:0]        out_de_reg, out_dn_reg;
    logic                     out_bridge_reg;

    logic signed [MW-1:0]     mul_a, mul_b;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  snap_sum, snap_off, snap_full;
    logic signed [C-1:0]      snap_base;
    logic [ACC_W-1:0]         rem_shift;
    logic                     rem_ge;
    logic signed [ACC_W-1:0]  d_full;
    logic [DW-1:0]            d_cand;
    logic                     accept, closes, emit_ok;

    assign accept  = in_valid && in_ready;
    assign closes  = !first_of_edge && prev_valid_reg;
    assign emit_ok = !out_valid_reg || out_ready;

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_P1:    begin mul_a = MW'(sx_reg);  mul_b = MW'(sx_reg); end
            S_P2:    begin mul_a = MW'(sy_reg);  mul_b = MW'(sy_reg); end
            S_P3:    begin mul_a = MW'(a_e_reg); mul_b = MW'(sx_reg); end
            S_P4:    begin mul_a = MW'(a_n_reg); mul_b = MW'(sy_reg); end
            S_T1:    begin mul_a = MW'(signed'({1'b0, t_reg})); mul_b = MW'(sx_reg); end
            S_T2:    begin mul_a = MW'(signed'({1'b0, t_reg})); mul_b = MW'(sy_reg); end
            S_D1:    begin mul_a = MW'(px_reg);  mul_b = MW'(px_reg); end
            S_D2:    begin mul_a = MW'(py_reg);  mul_b = MW'(py_reg); end
            default: begin mul_a = '0;           mul_b = '0;          end
        endcase
    end

    assign prod_ext = ACC_W'(prod_reg);

    // start + floor((t*seg + half) / 2^F)
    assign snap_base = (state_reg == S_T2) ? a_e_reg : a_n_reg;
    assign snap_sum  = prod_ext + ROUND_HALF;
    assign snap_off  = snap_sum >>> F;
    assign snap_full = ACC_W'(snap_base) + snap_off;

    assign rem_shift = {rem_reg[ACC_W-2:0], 1'b0};
    assign rem_ge    = rem_shift >= $unsigned(len_reg);

    assign d_full = acc_reg + prod_ext;
    assign d_cand = d_full[DW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = closes ? S_P1 : S_FIN;
            S_P1:   state_next = S_P2;
            S_P2:   state_next = S_P3;
            S_P3:   state_next = S_P4;
            S_P4:   state_next = S_P5;
            S_P5:   state_next = S_CHK;
            S_CHK:
            begin
                if (len_reg == '0 || dot_reg <= 0 || $unsigned(dot_reg) >= $unsigned(len_reg))
                    state_next = S_D1;
                else
                    state_next = S_DIV;
            end
            S_DIV:  if (cnt_reg == CNT_LAST) state_next = S_T1;
            S_T1:   state_next = S_T2;
            S_T2:   state_next = S_T3;
            S_T3:   state_next = S_D1;
            S_D1:   state_next = S_D2;
            S_D2:   state_next = S_D3;
            S_D3:   state_next = S_FIN;
            S_FIN:  if (!last_reg || emit_ok) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    a_e_reg    <= prev_e_reg;
                    a_n_reg    <= prev_n_reg;
                    b_e_reg    <= east;
                    b_n_reg    <= north;
                    sx_reg     <= (C+1)'(east) - (C+1)'(prev_e_reg);
                    sy_reg     <= (C+1)'(north) - (C+1)'(prev_n_reg);
                    id_reg     <= edge_id;
                    bridge_reg <= on_bridge;
                    last_reg   <= last_of_query;
                end
            end
            S_P2: len_reg <= prod_ext;
            S_P3: len_reg <= len_reg + prod_ext;
            S_P4: dot_reg <= -prod_ext;
            S_P5: dot_reg <= dot_reg - prod_ext;
            S_CHK:
            begin
                rem_reg <= dot_reg;
                t_reg   <= '0;
                cnt_reg <= '0;
                if (len_reg == '0 || dot_reg <= 0)
                begin
                    px_reg <= a_e_reg;
                    py_reg <= a_n_reg;
                end
                else
                begin
                    px_reg <= b_e_reg;
                    py_reg <= b_n_reg;
                end
            end
            S_DIV:
            begin
                rem_reg <= rem_ge ? rem_shift - $unsigned(len_reg) : rem_shift;
                t_reg   <= {t_reg[F-2:0], rem_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_T2: px_reg <= snap_full[C-1:0];
            S_T3: py_reg <= snap_full[C-1:0];
            S_D2: acc_reg <= prod_ext;
            default: ;
        endcase
    end

    // control and query state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            max_dist_reg    <= npp_pkg::MAX_DIST_RESET;
            prev_e_reg      <= '0;
            prev_n_reg      <= '0;
            prev_valid_reg  <= 1'b0;
            best_dist_reg   <= npp_pkg::DIST_INFINITY;
            found_reg       <= 1'b0;
            best_id_reg     <= '0;
            best_e_reg      <= '0;
            best_n_reg      <= '0;
            best_de_reg     <= '0;
            best_dn_reg     <= '0;
            best_bridge_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                max_dist_reg <= cfg_wdata;

            if (state_reg == S_FIN && last_reg && emit_ok)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (accept)
            begin
                prev_e_reg     <= east;
                prev_n_reg     <= north;
                prev_valid_reg <= 1'b1;
            end

            // strictly nearer wins, so an earlier segment keeps a tie
            if (state_reg == S_D3 && d_cand < best_dist_reg)
            begin
                best_dist_reg   <= d_cand;
                found_reg       <= 1'b1;
                best_id_reg     <= id_reg;
                best_e_reg      <= px_reg;
                best_n_reg      <= py_reg;
                best_de_reg     <= sx_reg;
                best_dn_reg     <= sy_reg;
                best_bridge_reg <= bridge_reg;
            end

            if (state_reg == S_FIN && last_reg && emit_ok)
            begin
                prev_e_reg      <= '0;
                prev_n_reg      <= '0;
                prev_valid_reg  <= 1'b0;
                best_dist_reg   <= npp_pkg::DIST_INFINITY;
                found_reg       <= 1'b0;
                best_id_reg     <= '0;
                best_e_reg      <= '0;
                best_n_reg      <= '0;
                best_de_reg     <= '0;
                best_dn_reg     <= '0;
                best_bridge_reg <= 1'b0;
            end
        end
    end

    // result payload; all fields but status read zero when no segment was seen
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && last_reg && emit_ok)
        begin
            out_id_reg     <= best_id_reg;
            out_e_reg      <= best_e_reg;
            out_n_reg      <= best_n_reg;
            out_de_reg     <= best_de_reg;
            out_dn_reg     <= best_dn_reg;
            out_bridge_reg <= best_bridge_reg;
            if (!found_reg)
            begin
                status_reg   <= npp_pkg::STATUS_NO_CAND;
                out_dist_reg <= '0;
            end
            else
            begin
                status_reg   <= (best_dist_reg > max_dist_reg) ? npp_pkg::STATUS_TOO_FAR
                                                               : npp_pkg::STATUS_OK;
                out_dist_reg <= best_dist_reg;
            end
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign best_edge       = out_id_reg;
    assign snapped_east    = out_e_reg;
    assign snapped_north   = out_n_reg;
    assign snapped_dist_sq = out_dist_reg;
    assign dir_east        = out_de_reg;
    assign dir_north       = out_dn_reg;
    assign best_on_bridge  = out_bridge_reg;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nearest_point_on_polyline. A directed table covers
// the corner cases, then random queries run under several distance limits;
// results are matched per field to the table or an in-bench projection model.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW = 24;
    localparam int FB = 16;
    localparam int IW = 32;
    localparam int DW = npp_pkg::DIST_W;
    localparam longint DIST_MASK = (longint'(1) << DW) - 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        npp_pkg::status_t      status;
        logic [IW-1:0]         edge_no;
        logic signed [CW-1:0]  snap_e;
        logic signed [CW-1:0]  snap_n;
        logic [DW-1:0]         dist_sq;
        logic signed [CW:0]    dir_e;
        logic signed [CW:0]    dir_n;
        logic                  bridge;
    } snap_res_t;

    typedef struct packed {
        logic signed [CW-1:0]  e;
        logic signed [CW-1:0]  n;
        logic [IW-1:0]         id;
        logic                  br;
        logic                  first;
        logic                  last;
        logic                  typed;
        snap_res_t             res;
    } vertex_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [DW-1:0]         cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [CW-1:0]  east = '0;
    logic signed [CW-1:0]  north = '0;
    logic [IW-1:0]         edge_id = '0;
    logic                  on_bridge = 1'b0;
    logic                  first_of_edge = 1'b0;
    logic                  last_of_query = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            status;
    logic [IW-1:0]         best_edge;
    logic signed [CW-1:0]  snapped_east;
    logic signed [CW-1:0]  snapped_north;
    logic [DW-1:0]         snapped_dist_sq;
    logic signed [CW:0]    dir_east;
    logic signed [CW:0]    dir_north;
    logic                  best_on_bridge;

    nearest_point_on_polyline dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .east(east), .north(north), .edge_id(edge_id), .on_bridge(on_bridge),
        .first_of_edge(first_of_edge), .last_of_query(last_of_query),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .best_edge(best_edge),
        .snapped_east(snapped_east), .snapped_north(snapped_north),
        .snapped_dist_sq(snapped_dist_sq), .dir_east(dir_east), .dir_north(dir_north),
        .best_on_bridge(best_on_bridge)
    );

    always #5 clk = ~clk;

    // projection model state
    longint    lim_sq;
    longint    prv_e, prv_n;
    bit        prv_ok;
    snap_res_t best;
    bit        have_best;

    snap_res_t pending_snaps[$];
    vertex_t   plan[$];
    int        mismatches = 0;
    int        cycles = 0;
    int        burst_left = 0;

    function automatic void clear_query();
        prv_e = 0;
        prv_n = 0;
        prv_ok = 0;
        have_best = 0;
        best = '0;
        best.dist_sq = '1;
    endfunction

    function automatic void project_segment(vertex_t v);
        longint ax, ay, bx, by, sx, sy, len, dot, px, py, r, t, d;
        ax = prv_e;
        ay = prv_n;
        bx = longint'(v.e);
        by = longint'(v.n);
        sx = bx - ax;
        sy = by - ay;
        len = sx * sx + sy * sy;
        dot = -(ax * sx) - (ay * sy);
        if (len == 0 || dot <= 0) begin
            px = ax;
            py = ay;
        end
        else if (dot >= len) begin
            px = bx;
            py = by;
        end
        else begin
            r = dot;
            t = 0;
            for (int i = 0; i < FB; i++) begin
                r = r << 1;
                t = t << 1;
                if (r >= len) begin
                    r = r - len;
                    t = t | 1;
                end
            end
            // round half up, floor on negatives
            px = ax + ((t * sx + (longint'(1) << (FB - 1))) >>> FB);
            py = ay + ((t * sy + (longint'(1) << (FB - 1))) >>> FB);
        end
        d = (px * px + py * py) & DIST_MASK;
        if (d < longint'({16'd0, best.dist_sq})) begin
            have_best = 1;
            best.dist_sq = d[DW-1:0];
            best.edge_no = v.id;
            best.snap_e = px[CW-1:0];
            best.snap_n = py[CW-1:0];
            best.dir_e = sx[CW:0];
            best.dir_n = sy[CW:0];
            best.bridge = v.br;
        end
    endfunction

    // returns 1 when the vertex ends a query; r holds the expected result
    function automatic bit take_vertex(vertex_t v, output snap_res_t r);
        if (!v.first && prv_ok)
            project_segment(v);
        prv_e = longint'(v.e);
        prv_n = longint'(v.n);
        prv_ok = 1;
        r = '0;
        if (!v.last)
            return 0;
        if (!have_best) begin
            r.status = npp_pkg::STATUS_NO_CAND;
        end
        else begin
            r = best;
            r.status = (longint'({16'd0, best.dist_sq}) > lim_sq) ? npp_pkg::STATUS_TOO_FAR
                                                                  : npp_pkg::STATUS_OK;
        end
        clear_query();
        return 1;
    endfunction

    function automatic vertex_t vx(int e, int n, logic [IW-1:0] id, bit br, bit f, bit l);
        vertex_t v;
        v = '0;
        v.e = e[CW-1:0];
        v.n = n[CW-1:0];
        v.id = id;
        v.br = br;
        v.first = f;
        v.last = l;
        return v;
    endfunction

    function automatic vertex_t with_result(vertex_t v, npp_pkg::status_t s,
                                            logic [IW-1:0] id, int se, int sn,
                                            longint d, bit br);
        v.typed = 1;
        v.res = '0;
        v.res.status = s;
        v.res.edge_no = id;
        v.res.snap_e = se[CW-1:0];
        v.res.snap_n = sn[CW-1:0];
        v.res.dist_sq = d[DW-1:0];
        v.res.bridge = br;
        return v;
    endfunction

    task automatic send_vertex(vertex_t v);
        snap_res_t r;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        east <= v.e;
        north <= v.n;
        edge_id <= v.id;
        on_bridge <= v.br;
        first_of_edge <= v.first;
        last_of_query <= v.last;
        do @(posedge clk); while (!in_ready);
        if (take_vertex(v, r))
            pending_snaps.push_back(v.typed ? v.res : r);
    endtask

    // wait until the block is quiet, then write the limit
    task automatic set_limit(longint val);
        in_valid <= 1'b0;
        while (pending_snaps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val[DW-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_sq = val & DIST_MASK;
    endtask

    function automatic int rand_coord(int span);
        if (span >= 8388607)
            return int'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic random_query();
        int nedges, nverts, span, i;
        logic [IW-1:0] id;
        bit br, noise;
        vertex_t v;
        case ($urandom_range(0, 3))
            0: span = 64;
            1, 2: span = 30000;
            default: span = 8388607;
        endcase
        nedges = $urandom_range(1, 3);
        for (int k = 0; k < nedges; k++) begin
            nverts = $urandom_range(1, 4);
            id = $urandom();
            br = $urandom_range(0, 1);
            for (i = 0; i < nverts; i++) begin
                noise = ($urandom_range(0, 9) == 0);
                v = vx(rand_coord(span), rand_coord(span), id, br, i == 0,
                       (k == nedges - 1) && (i == nverts - 1));
                if (noise) begin
                    v.first = $urandom_range(0, 1);
                    v.last = ($urandom_range(0, 3) == 0);
                end
                send_vertex(v);
            end
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // receiver stalls in phases: always ready, coin toss, mostly stalled
    always @(posedge clk)
    begin
        case ((cycles / 700) % 3)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        snap_res_t x, got;
        if (rst_n && out_valid && out_ready) begin
            got = '{npp_pkg::status_t'(status), best_edge, snapped_east, snapped_north,
                    snapped_dist_sq, dir_east, dir_north, best_on_bridge};
            if (pending_snaps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %p", got);
            end
            else begin
                x = pending_snaps.pop_front();
                if (x.status !== got.status || x.edge_no !== got.edge_no ||
                    x.snap_e !== got.snap_e || x.snap_n !== got.snap_n ||
                    x.dist_sq !== got.dist_sq || x.dir_e !== got.dir_e ||
                    x.dir_n !== got.dir_n || x.bridge !== got.bridge) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch\n  exp %p\n  got %p", x, got);
                end
            end
        end
    end

    initial
    begin
        longint limits[6];
        lim_sq = longint'(npp_pkg::MAX_DIST_RESET);
        clear_query();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no edge start after reset: lone vertex, no candidate
        plan.push_back(with_result(vx(0, 0, 5, 0, 0, 1), npp_pkg::STATUS_NO_CAND,
                                   0, 0, 0, 0, 0));
        // zero-length segment at the origin
        plan.push_back(vx(0, 0, 7, 1, 1, 0));
        plan.push_back(with_result(vx(0, 0, 9, 1, 0, 1), npp_pkg::STATUS_OK,
                                   9, 0, 0, 0, 1));
        // just beyond the default 100 m limit, still reported in full
        plan.push_back(vx(25601, 0, 3, 0, 1, 0));
        plan.push_back(with_result(vx(25601, 0, 32'hFFFF_FFFF, 0, 0, 1),
                                   npp_pkg::STATUS_TOO_FAR,
                                   32'hFFFF_FFFF, 25601, 0, 64'd655411201, 0));
        // exactly on the limit
        plan.push_back(vx(0, 25600, 4, 0, 1, 0));
        plan.push_back(with_result(vx(0, 25600, 4, 1, 0, 1), npp_pkg::STATUS_OK,
                                   4, 0, 25600, 64'd655360000, 1));
        // full-scale diagonals
        plan.push_back(vx(-8388608, -8388608, 1, 0, 1, 0));
        plan.push_back(vx(8388607, 8388607, 2, 1, 0, 0));
        plan.push_back(vx(8388607, -8388608, 32'h8000_0000, 0, 1, 0));
        plan.push_back(vx(-8388608, 8388607, 32'h8000_0001, 1, 0, 1));
        // missing start after query end, then interior projection and ties
        plan.push_back(vx(100, 50, 11, 0, 0, 0));
        plan.push_back(vx(100, -50, 12, 1, 0, 0));
        plan.push_back(vx(300, -60, 13, 0, 0, 0));
        plan.push_back(vx(-100, 50, 14, 0, 1, 0));
        plan.push_back(vx(-100, -50, 15, 0, 0, 0));
        // clamp to start, clamp to end
        plan.push_back(vx(10, 0, 16, 0, 1, 0));
        plan.push_back(vx(20, 0, 17, 1, 0, 0));
        plan.push_back(vx(-20, 3, 18, 0, 1, 0));
        plan.push_back(vx(-10, 3, 19, 1, 0, 0));
        plan.push_back(vx(200, 5, 20, 0, 1, 0));
        plan.push_back(vx(-201, 7, 21, 1, 0, 1));
        foreach (plan[i])
            send_vertex(plan[i]);

        limits = '{64'd0, 64'hFFFF_FFFF_FFFF, 64'h8000_0000_0000,
                   64'd655360000, 64'd1000, 64'd900000000};
        foreach (limits[p]) begin
            set_limit(limits[p]);
            for (int q = 0; q < 50; q++)
                random_query();
        end
        set_limit(longint'($urandom_range(0, 32'h7FFF_FFFF)));
        for (int q = 0; q < 20; q++)
            random_query();

        in_valid <= 1'b0;
        while (pending_snaps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
